// ----- design/tfsp_pkg.sv -----
// Shared types and constants of the target follow speed planner.
`default_nettype none
package tfsp_pkg;

  // Age beyond which a sensor sample counts as stale, in milliseconds.
  localparam int unsigned STALE_LIMIT_MS = 300;

  // Hold-decay factor 0.85 in Q0.8.
  localparam int unsigned HOLD_DECAY_Q8 = 218;

  // Quotient bits of the deadband ratio divide.
  localparam int unsigned DIV_STEPS = 24;

  // Mode codes as reported on the result.
  localparam logic [1:0] MODE_STOP  = 2'd0;
  localparam logic [1:0] MODE_TRACK = 2'd1;
  localparam logic [1:0] MODE_HOLD  = 2'd2;

  // Operations of the shared arithmetic unit.
  localparam logic OP_MUL = 1'b0;
  localparam logic OP_DIV = 1'b1;

  typedef struct packed {
    logic [15:0]        desired;
    logic [15:0]        min_safe;
    logic [11:0]        deadband;
    logic [11:0]        gain;
    logic [11:0]        fwd_max;
    logic signed [12:0] rev_max;
    logic [15:0]        accel;
    logic [15:0]        hold_time;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic               op;
    logic signed [17:0] mul_a;
    logic signed [17:0] mul_b;
    logic [23:0]        div_num;
    logic [11:0]        div_den;
  } alu_req_t;

  typedef struct packed {
    logic               done;
    logic signed [35:0] product;
    logic [23:0]        quotient;
  } alu_rsp_t;

endpackage
`default_nettype wire

// ----- design/tfsp_regs.sv -----
// Configuration register file behind the APB-style port.
`default_nettype none
module tfsp_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output tfsp_pkg::cfg_t cfg
);
  import tfsp_pkg::*;

  localparam logic [2:0] REG_DESIRED  = 3'd0;
  localparam logic [2:0] REG_MIN_SAFE = 3'd1;
  localparam logic [2:0] REG_DEADBAND = 3'd2;
  localparam logic [2:0] REG_GAIN     = 3'd3;
  localparam logic [2:0] REG_FWD_MAX  = 3'd4;
  localparam logic [2:0] REG_REV_MAX  = 3'd5;
  localparam logic [2:0] REG_ACCEL    = 3'd6;
  localparam logic [2:0] REG_HOLD     = 3'd7;

  logic       wr_en;
  logic [2:0] reg_index;

  assign wr_en     = psel && penable && pwrite;
  assign reg_index = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.desired   <= 16'd700;
      cfg.min_safe  <= 16'd150;
      cfg.deadband  <= 12'd20;
      cfg.gain      <= 12'd256;
      cfg.fwd_max   <= 12'd500;
      cfg.rev_max   <= -13'sd600;
      cfg.accel     <= 16'd333;
      cfg.hold_time <= 16'd400;
    end else if (wr_en) begin
      unique case (reg_index)
        REG_DESIRED:  cfg.desired   <= pwdata[15:0];
        REG_MIN_SAFE: cfg.min_safe  <= pwdata[15:0];
        REG_DEADBAND: cfg.deadband  <= pwdata[11:0];
        REG_GAIN:     cfg.gain      <= pwdata[11:0];
        REG_FWD_MAX:  cfg.fwd_max   <= pwdata[11:0];
        REG_REV_MAX:  cfg.rev_max   <= $signed(pwdata[12:0]);
        REG_ACCEL:    cfg.accel     <= pwdata[15:0];
        REG_HOLD:     cfg.hold_time <= pwdata[15:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_DESIRED:  prdata = {16'd0, cfg.desired};
      REG_MIN_SAFE: prdata = {16'd0, cfg.min_safe};
      REG_DEADBAND: prdata = {20'd0, cfg.deadband};
      REG_GAIN:     prdata = {20'd0, cfg.gain};
      REG_FWD_MAX:  prdata = {20'd0, cfg.fwd_max};
      REG_REV_MAX:  prdata = 32'(cfg.rev_max);
      REG_ACCEL:    prdata = {16'd0, cfg.accel};
      REG_HOLD:     prdata = {16'd0, cfg.hold_time};
      default:      prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ----- design/tfsp_alu.sv -----
// Shared arithmetic unit: a registered signed multiply and a bit-serial unsigned divide.
`default_nettype none
module tfsp_alu (
  input  logic               clk,
  input  logic               rst,
  input  tfsp_pkg::alu_req_t req,
  output tfsp_pkg::alu_rsp_t rsp
);
  import tfsp_pkg::*;

  logic               busy;
  logic               done;
  logic [4:0]         count;
  logic signed [35:0] product;
  logic [23:0]        quot;
  logic [11:0]        rem;
  logic [11:0]        den;

  logic [12:0] rem_shift;
  logic [13:0] trial;
  logic        q_bit;
  logic [11:0] rem_next;

  // Restoring division: the dividend shifts out of the top of quot while
  // quotient bits shift in at the bottom.
  assign rem_shift = {rem, quot[23]};
  assign trial     = {1'b0, rem_shift} - {2'b00, den};
  assign q_bit     = !trial[13];
  assign rem_next  = q_bit ? trial[11:0] : rem_shift[11:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= 5'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        if (req.op == OP_MUL) begin
          done <= 1'b1;
        end else begin
          busy  <= 1'b1;
          count <= 5'd0;
        end
      end else if (busy) begin
        if (count == 5'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          count <= count + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      if (req.op == OP_MUL) begin
        product <= req.mul_a * req.mul_b;
      end else begin
        quot <= req.div_num;
        rem  <= 12'd0;
        den  <= req.div_den;
      end
    end else if (busy) begin
      quot <= {quot[22:0], q_bit};
      rem  <= rem_next;
    end
  end

  assign rsp.done     = done;
  assign rsp.product  = product;
  assign rsp.quotient = quot;

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("arithmetic unit started while a divide is running");

  a_mul_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (req.start && req.op == OP_MUL) |=> rsp.done)
    else $error("multiply did not finish in one cycle");

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    busy |-> (den != 12'd0))
    else $error("divide running with a zero divisor");

endmodule
`default_nettype wire

// ----- design/target_follow_speed_planner.sv -----
// Top level of the target follow speed planner: sequencer around the shared arithmetic unit.
// Items are taken one at a time: in_ready is high only while idle, and the deadband
// path adds the 24-step bit-serial divide in the shared unit after its multiply.
// A finished result waits in the output register while the next item is taken.
// Synchronous active-high reset: stop mode, zero speed, last-seen time zero, defaults.
`default_nettype none
module target_follow_speed_planner #(
  parameter int unsigned STALE_LIMIT = tfsp_pkg::STALE_LIMIT_MS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               target_present,
  input  logic [31:0]        sample_time_ms,
  input  logic [15:0]        front_distance_mm,
  input  logic [31:0]        now_time_ms,
  input  logic [9:0]         tick_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [12:0] speed_mm_s,
  output logic [1:0]         mode
);
  import tfsp_pkg::*;

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_EVAL      = 3'd1;
  localparam logic [2:0] ST_RAW_WAIT  = 3'd2;
  localparam logic [2:0] ST_DIV_WAIT  = 3'd3;
  localparam logic [2:0] ST_SLEW_WAIT = 3'd4;
  localparam logic [2:0] ST_DONE      = 3'd5;

  localparam logic [2:0] PATH_STOP  = 3'd0;
  localparam logic [2:0] PATH_BACK  = 3'd1;
  localparam logic [2:0] PATH_DEAD  = 3'd2;
  localparam logic [2:0] PATH_DEAD0 = 3'd3;
  localparam logic [2:0] PATH_PROP  = 3'd4;
  localparam logic [2:0] PATH_HOLD  = 3'd5;

  cfg_t     cfg;
  alu_req_t req;
  alu_rsp_t rsp;

  logic [2:0]         state;
  logic [2:0]         path;
  logic [1:0]         mode_reg;
  logic [31:0]        last_seen_time;
  logic signed [12:0] previous_speed;
  logic               has_r;
  logic [31:0]        stamp_r;
  logic [15:0]        dist_r;
  logic [31:0]        now_r;
  logic [9:0]         dt_r;
  logic signed [13:0] v_raw;
  logic               dead_neg;
  logic signed [12:0] slew_r;

  tfsp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  tfsp_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign pready   = 1'b1;
  assign in_ready = (state == ST_IDLE);

  // Freshness and mode decision.
  logic        stale;
  logic        seen;
  logic [1:0]  mode_new;
  logic [31:0] sample_age;
  logic [31:0] unseen_time;

  assign sample_age  = now_r - stamp_r;
  assign unseen_time = now_r - last_seen_time;
  assign stale = (stamp_r == 32'd0) ||
                 ((now_r > stamp_r) && (sample_age > 32'(STALE_LIMIT)));
  assign seen  = has_r && !stale;

  always_comb begin
    unique case (mode_reg)
      MODE_TRACK: mode_new = seen ? MODE_TRACK : MODE_HOLD;
      MODE_HOLD: begin
        if (seen) begin
          mode_new = MODE_TRACK;
        end else if (unseen_time > {16'd0, cfg.hold_time}) begin
          mode_new = MODE_STOP;
        end else begin
          mode_new = MODE_HOLD;
        end
      end
      default: mode_new = seen ? MODE_TRACK : MODE_STOP;
    endcase
  end

  // Path selection for the raw command.
  logic signed [16:0] err;
  logic [15:0]        aerr;
  logic signed [16:0] back_diff;
  logic [2:0]         path_new;

  assign err       = $signed({1'b0, dist_r}) - $signed({1'b0, cfg.desired});
  assign aerr      = err[16] ? 16'(-err) : err[15:0];
  assign back_diff = $signed({1'b0, cfg.min_safe}) - $signed({1'b0, dist_r});

  always_comb begin
    if (mode_new == MODE_TRACK) begin
      if (dist_r <= cfg.min_safe) begin
        path_new = PATH_BACK;
      end else if (aerr <= {4'd0, cfg.deadband}) begin
        path_new = (cfg.deadband == 12'd0) ? PATH_DEAD0 : PATH_DEAD;
      end else begin
        path_new = PATH_PROP;
      end
    end else if (mode_new == MODE_HOLD) begin
      path_new = PATH_HOLD;
    end else begin
      path_new = PATH_STOP;
    end
  end

  // Raw command from the product, truncated toward zero after the Q8 shift.
  logic               prod_neg;
  logic [35:0]        prod_mag;
  logic [27:0]        prod_q8;
  logic signed [28:0] tq;
  logic signed [28:0] rev_ext;
  logic signed [28:0] fwd_ext;
  logic signed [28:0] prop_min;
  logic signed [28:0] back_v;
  logic signed [28:0] raw_sel;

  assign prod_neg = rsp.product[35];
  assign prod_mag = prod_neg ? 36'(-rsp.product) : rsp.product;
  assign prod_q8  = prod_mag[35:8];
  assign tq       = prod_neg ? -$signed({1'b0, prod_q8}) : $signed({1'b0, prod_q8});
  assign rev_ext  = 29'(cfg.rev_max);
  assign fwd_ext  = $signed({17'd0, cfg.fwd_max});
  assign prop_min = (tq < fwd_ext) ? tq : fwd_ext;
  assign back_v   = -$signed({1'b0, prod_q8});

  always_comb begin
    case (path)
      PATH_BACK: raw_sel = (back_v > rev_ext) ? back_v : rev_ext;
      PATH_PROP: raw_sel = (prop_min > rev_ext) ? prop_min : rev_ext;
      PATH_HOLD: raw_sel = tq;
      default:   raw_sel = 29'sd0;
    endcase
  end

  // Slew limit against the previous command.
  logic [17:0]        maxdv;
  logic signed [19:0] prev_ext;
  logic signed [19:0] v_ext;
  logic signed [19:0] dv;
  logic signed [19:0] maxdv_ext;
  logic signed [19:0] slewed;
  logic signed [12:0] slew_next;

  assign maxdv     = rsp.product[25:8];
  assign prev_ext  = 20'(previous_speed);
  assign v_ext     = 20'(v_raw);
  assign dv        = v_ext - prev_ext;
  assign maxdv_ext = $signed({2'b00, maxdv});

  always_comb begin
    if (dt_r == 10'd0) begin
      slewed = prev_ext;
    end else if (dv > maxdv_ext) begin
      slewed = prev_ext + maxdv_ext;
    end else if (dv < -maxdv_ext) begin
      slewed = prev_ext - maxdv_ext;
    end else begin
      slewed = v_ext;
    end
    if (slewed > 20'sd4095) begin
      slew_next = 13'sd4095;
    end else if (slewed < -20'sd4096) begin
      slew_next = -13'sd4096;
    end else begin
      slew_next = slewed[12:0];
    end
  end

  // Requests to the shared unit.
  always_comb begin
    req.start   = 1'b0;
    req.op      = OP_MUL;
    req.mul_a   = 18'sd0;
    req.mul_b   = 18'sd0;
    req.div_num = prod_mag[23:0];
    req.div_den = cfg.deadband;
    unique case (state) inside
      ST_EVAL: begin
        req.start = 1'b1;
        case (path_new)
          PATH_BACK: begin
            req.mul_a = $signed({6'd0, cfg.gain});
            req.mul_b = 18'(back_diff);
          end
          PATH_PROP: begin
            req.mul_a = $signed({6'd0, cfg.gain});
            req.mul_b = 18'(err);
          end
          PATH_DEAD: begin
            req.mul_a = 18'(previous_speed);
            req.mul_b = $signed({2'b00, aerr});
          end
          PATH_HOLD: begin
            req.mul_a = 18'(previous_speed);
            req.mul_b = 18'(HOLD_DECAY_Q8);
          end
          default: ;
        endcase
      end
      ST_RAW_WAIT, ST_DIV_WAIT: begin
        req.start = rsp.done;
        if (state == ST_RAW_WAIT && path == PATH_DEAD) begin
          req.op = OP_DIV;
        end else begin
          req.mul_a = $signed({2'b00, cfg.accel});
          req.mul_b = $signed({8'd0, dt_r});
        end
      end
      default: ;
    endcase
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      mode_reg       <= MODE_STOP;
      last_seen_time <= 32'd0;
      previous_speed <= 13'sd0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          mode_reg <= mode_new;
          if (seen) begin
            last_seen_time <= now_r;
          end
          state <= ST_RAW_WAIT;
        end
        ST_RAW_WAIT: begin
          if (rsp.done) begin
            state <= (path == PATH_DEAD) ? ST_DIV_WAIT : ST_SLEW_WAIT;
          end
        end
        ST_DIV_WAIT: begin
          if (rsp.done) begin
            state <= ST_SLEW_WAIT;
          end
        end
        ST_SLEW_WAIT: begin
          if (rsp.done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            previous_speed <= slew_r;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      has_r   <= target_present;
      stamp_r <= sample_time_ms;
      dist_r  <= front_distance_mm;
      now_r   <= now_time_ms;
      dt_r    <= tick_ms;
    end
    if (state == ST_EVAL) begin
      path <= path_new;
    end
    if (state == ST_RAW_WAIT && rsp.done) begin
      v_raw    <= raw_sel[13:0];
      dead_neg <= prod_neg;
    end
    if (state == ST_DIV_WAIT && rsp.done) begin
      v_raw <= dead_neg ? -$signed(rsp.quotient[13:0]) : $signed(rsp.quotient[13:0]);
    end
    if (state == ST_SLEW_WAIT && rsp.done) begin
      slew_r <= slew_next;
    end
    if (state == ST_DONE && (!out_valid || out_ready)) begin
      speed_mm_s <= slew_r;
      mode       <= mode_reg;
    end
  end

  a_accept_eval: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_EVAL))
    else $error("accepted item did not start evaluation");

  a_out_matches_prev: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (speed_mm_s == previous_speed))
    else $error("pending result differs from the stored speed");

  a_div_only_deadband: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV_WAIT) |-> (path == PATH_DEAD))
    else $error("divide wait entered outside the deadband path");

endmodule
`default_nettype wire

// ----- bench/target_follow_speed_planner_test.sv -----
// Self-checking testbench for the target follow speed planner.
`timescale 1ns / 1ps
module target_follow_speed_planner_test;
  import tfsp_pkg::*;

  localparam int REG_DESIRED  = 0;
  localparam int REG_MIN_SAFE = 1;
  localparam int REG_DEADBAND = 2;
  localparam int REG_GAIN     = 3;
  localparam int REG_FWD_MAX  = 4;
  localparam int REG_REV_MAX  = 5;
  localparam int REG_ACCEL    = 6;
  localparam int REG_HOLD     = 7;
  localparam int NUM_REGS     = 8;

  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 2000;
  localparam int ITEMS_PER_SETTING = 150;

  localparam cfg_t DEFAULT_CFG = '{desired: 16'd700, min_safe: 16'd150, deadband: 12'd20,
                                   gain: 12'd256, fwd_max: 12'd500, rev_max: -13'sd600,
                                   accel: 16'd333, hold_time: 16'd400};

  typedef struct packed {
    logic        has;
    logic [31:0] stamp;
    logic [15:0] distance;
    logic [31:0] now;
    logic [9:0]  dt;
  } tick_t;

  typedef struct packed {
    logic [12:0] speed;
    logic [1:0]  mode;
  } plan_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [4:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid;
  logic               in_ready;
  logic               target_present;
  logic [31:0]        sample_time_ms;
  logic [15:0]        front_distance_mm;
  logic [31:0]        now_time_ms;
  logic [9:0]         tick_ms;
  logic               out_valid;
  logic               out_ready;
  logic signed [12:0] speed_mm_s;
  logic [1:0]         mode;

  target_follow_speed_planner DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .target_present(target_present), .sample_time_ms(sample_time_ms),
    .front_distance_mm(front_distance_mm), .now_time_ms(now_time_ms), .tick_ms(tick_ms),
    .out_valid(out_valid), .out_ready(out_ready),
    .speed_mm_s(speed_mm_s), .mode(mode)
  );

  // Predictor state, mirroring the block's registers.
  cfg_t        cfg = DEFAULT_CFG;
  logic [1:0]  plan_mode = MODE_STOP;
  logic [31:0] last_seen = '0;
  int          prev_speed = 0;

  plan_t speed_plans[$];
  int    mismatches = 0;
  int    idle_cycles = 0;
  int    tx_gap_max = 10;
  int    rx_gap_max = 10;
  int    rx_hold_cycles = 0;
  logic [31:0] clock_ms = 32'd5000;
  int    absent_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint bound_to(longint x, longint lo, longint hi);
    longint m;
    m = (x < hi) ? x : hi;
    return (m > lo) ? m : lo;
  endfunction

  // Advances the predicted state by one tick and returns the expected result.
  function automatic plan_t plan_speed(tick_t t);
    logic [31:0] age;
    logic [31:0] since_seen;
    logic        stale;
    logic        seen;
    longint      prev;
    longint      v;
    longint      dl;
    longint      err;
    longint      aerr;
    longint      maxdv;
    longint      dv;
    plan_t       r;
    age = t.now - t.stamp;
    stale = (t.stamp == 32'd0) || (t.now > t.stamp && age > STALE_LIMIT_MS);
    seen = t.has && !stale;
    prev = prev_speed;
    v = 0;
    if (seen) last_seen = t.now;
    since_seen = t.now - last_seen;
    case (plan_mode)
      MODE_TRACK: begin
        if (!seen) plan_mode = MODE_HOLD;
      end
      MODE_HOLD: begin
        if (seen) plan_mode = MODE_TRACK;
        else if (since_seen > {16'd0, cfg.hold_time}) plan_mode = MODE_STOP;
      end
      default: begin
        plan_mode = seen ? MODE_TRACK : MODE_STOP;
      end
    endcase

    if (plan_mode == MODE_TRACK) begin
      dl = longint'(t.distance);
      err = dl - longint'(cfg.desired);
      aerr = (err < 0) ? -err : err;
      if (dl <= longint'(cfg.min_safe)) begin
        v = -((longint'(cfg.gain) * (longint'(cfg.min_safe) - dl)) / 256);
        v = bound_to(v, longint'(cfg.rev_max), 0);
      end else if (aerr <= longint'(cfg.deadband)) begin
        // SystemVerilog division already truncates toward zero.
        if (cfg.deadband == 12'd0) v = 0;
        else v = (prev * aerr) / longint'(cfg.deadband);
      end else begin
        v = bound_to((longint'(cfg.gain) * err) / 256, longint'(cfg.rev_max),
                     longint'(cfg.fwd_max));
      end
    end else if (plan_mode == MODE_HOLD) begin
      v = (prev * longint'(HOLD_DECAY_Q8)) / 256;
    end

    if (t.dt == 10'd0) begin
      v = prev;
    end else begin
      maxdv = (longint'(cfg.accel) * longint'(t.dt)) >>> 8;
      dv = v - prev;
      if (dv > maxdv) v = prev + maxdv;
      if (dv < -maxdv) v = prev - maxdv;
    end
    v = bound_to(v, -4096, 4095);
    prev_speed = int'(v);
    r.speed = 13'(v);
    r.mode = plan_mode;
    return r;
  endfunction

  function automatic void note_failure(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  // Every accepted item is predicted at the edge that takes it.
  always @(posedge clk) begin
    tick_t t;
    if (!rst && in_valid && in_ready) begin
      t.has = target_present;
      t.stamp = sample_time_ms;
      t.distance = front_distance_mm;
      t.now = now_time_ms;
      t.dt = tick_ms;
      speed_plans.push_back(plan_speed(t));
    end
  end

  always @(posedge clk) begin
    plan_t want;
    if (!rst && out_valid && out_ready) begin
      if (speed_plans.size() == 0) begin
        note_failure($sformatf("%0t: result with nothing expected: speed %0d mode %0d",
                               $realtime, speed_mm_s, mode));
      end else begin
        want = speed_plans.pop_front();
        if (speed_mm_s !== want.speed || mode !== want.mode)
          note_failure($sformatf("%0t: expected speed %0d mode %0d, got speed %0d mode %0d",
                                 $realtime, $signed(want.speed), want.mode, speed_mm_s, mode));
      end
    end
  end

  // Ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random ready gaps, plus a long hold-off when a test asks for one.
  initial begin
    int gap;
    out_ready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        out_ready = 1'b0;
        repeat (rx_hold_cycles) @(negedge clk);
        rx_hold_cycles = 0;
      end
      gap = $urandom_range(0, rx_gap_max);
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // All driving tasks are entered and left just after a falling edge.
  task automatic send_tick(input tick_t t);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    target_present = t.has;
    sample_time_ms = t.stamp;
    front_distance_mm = t.distance;
    now_time_ms = t.now;
    tick_ms = t.dt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_plans();
    in_valid = 1'b0;
    while (speed_plans.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic reg_write(input int idx, input logic [31:0] val);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = 5'(idx * 4);
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      REG_DESIRED:  cfg.desired = val[15:0];
      REG_MIN_SAFE: cfg.min_safe = val[15:0];
      REG_DEADBAND: cfg.deadband = val[11:0];
      REG_GAIN:     cfg.gain = val[11:0];
      REG_FWD_MAX:  cfg.fwd_max = val[11:0];
      REG_REV_MAX:  cfg.rev_max = val[12:0];
      REG_ACCEL:    cfg.accel = val[15:0];
      REG_HOLD:     cfg.hold_time = val[15:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input cfg_t c);
    drain_plans();
    reg_write(REG_DESIRED, {16'd0, c.desired});
    reg_write(REG_MIN_SAFE, {16'd0, c.min_safe});
    reg_write(REG_DEADBAND, {20'd0, c.deadband});
    reg_write(REG_GAIN, {20'd0, c.gain});
    reg_write(REG_FWD_MAX, {20'd0, c.fwd_max});
    reg_write(REG_REV_MAX, {19'd0, c.rev_max});
    reg_write(REG_ACCEL, {16'd0, c.accel});
    reg_write(REG_HOLD, {16'd0, c.hold_time});
  endtask

  function automatic tick_t mk_tick(logic has, logic [31:0] stamp, logic [15:0] distance,
                                    logic [31:0] now, logic [9:0] dt);
    tick_t t;
    t.has = has;
    t.stamp = stamp;
    t.distance = distance;
    t.now = now;
    t.dt = dt;
    return t;
  endfunction

  // Mostly coherent time lines with runs of lost target, plus some noise.
  function automatic tick_t next_random_tick();
    tick_t t;
    int    step;
    int    pick;
    int    w;
    int    d;
    step = $urandom_range(0, 60);
    pick = $urandom_range(0, 99);
    if (pick < 3) clock_ms = $urandom;
    else if (pick < 5) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 100);
    else clock_ms = clock_ms + step;
    t.now = clock_ms;
    t.dt = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1023)) : 10'(step);

    pick = $urandom_range(0, 99);
    if (pick < 4) t.stamp = 32'd0;
    else if (pick < 8) t.stamp = $urandom;
    else if (pick < 12) t.stamp = clock_ms + $urandom_range(1, 50);
    else t.stamp = clock_ms - $urandom_range(0, 320);

    if (absent_left == 0 && $urandom_range(0, 19) == 0) absent_left = $urandom_range(1, 30);
    if (absent_left > 0) begin
      absent_left--;
      t.has = ($urandom_range(0, 3) == 0);
      if (t.has) t.stamp = clock_ms - $urandom_range(301, 2000);
    end else begin
      t.has = ($urandom_range(0, 19) != 0);
    end

    pick = $urandom_range(0, 99);
    w = int'(cfg.deadband) + 30;
    if (pick < 35) d = int'(cfg.desired) + int'($urandom_range(0, 2 * w)) - w;
    else if (pick < 55) d = int'(cfg.min_safe) + int'($urandom_range(0, 40)) - 20;
    else if (pick < 65) d = ($urandom_range(0, 1) == 0) ? 0 : 65535;
    else if (pick < 80) d = int'(cfg.desired) + int'($urandom_range(0, 2000)) - 1000;
    else d = $urandom_range(0, 65535);
    t.distance = 16'(bound_to(d, 0, 65535));
    return t;
  endfunction

  // Reset settings: acquisition, each tracking branch, staleness edges, hold, stop, wrap.
  task automatic test_directed_ticks();
    send_tick(mk_tick(1'b0, 32'd990, 16'd1200, 32'd1000, 10'd10));
    send_tick(mk_tick(1'b1, 32'd0, 16'd1200, 32'd1005, 10'd5));
    send_tick(mk_tick(1'b1, 32'd1000, 16'd1200, 32'd1010, 10'd10));
    send_tick(mk_tick(1'b1, 32'd1030, 16'd65535, 32'd1020, 10'd1023));
    send_tick(mk_tick(1'b1, 32'd740, 16'd710, 32'd1040, 10'd20));
    send_tick(mk_tick(1'b1, 32'd759, 16'd710, 32'd1060, 10'd20));
    send_tick(mk_tick(1'b0, 32'd1060, 16'd710, 32'd1070, 10'd0));
    send_tick(mk_tick(1'b1, 32'd1080, 16'd100, 32'd1080, 10'd50));
    send_tick(mk_tick(1'b1, 32'd1090, 16'd0, 32'd1090, 10'd1023));
    send_tick(mk_tick(1'b1, 32'd1100, 16'd150, 32'd1100, 10'd10));
    send_tick(mk_tick(1'b1, 32'd1110, 16'd1000, 32'd1110, 10'd1023));
    send_tick(mk_tick(1'b1, 32'd1120, 16'd700, 32'd1120, 10'd10));
    send_tick(mk_tick(1'b1, 32'd1130, 16'd300, 32'd1130, 10'd1023));
    send_tick(mk_tick(1'b0, 32'd1130, 16'd300, 32'd1330, 10'd200));
    send_tick(mk_tick(1'b0, 32'd1130, 16'd300, 32'd1530, 10'd200));
    send_tick(mk_tick(1'b0, 32'd1130, 16'd300, 32'd1730, 10'd200));
    send_tick(mk_tick(1'b1, 32'hFFFF_FF00, 16'd900, 32'hFFFF_FFF0, 10'd100));
    send_tick(mk_tick(1'b1, 32'hFFFF_FFF0, 16'd900, 32'h0000_0020, 10'd48));
    send_tick(mk_tick(1'b0, 32'h0000_0020, 16'd900, 32'h0000_0100, 10'd100));
    send_tick(mk_tick(1'b0, 32'h0000_0020, 16'd900, 32'h0000_0300, 10'd100));
    send_tick(mk_tick(1'b1, 32'hFFFF_FFFF, 16'd65535, 32'hFFFF_FFFF, 10'd1023));
    send_tick(mk_tick(1'b1, 32'd1, 16'd65535, 32'hFFFF_FFFF, 10'd1023));
    send_tick(mk_tick(1'b1, 32'hAAAA_5555, 16'h5555, 32'h5555_AAAA, 10'h155));
  endtask

  // Zero deadband, then a reverse limit above the forward limit.
  task automatic test_special_limits();
    cfg_t c;
    c = DEFAULT_CFG;
    c.deadband = 12'd0;
    c.accel = 16'hFFFF;
    apply_settings(c);
    send_tick(mk_tick(1'b1, 32'd2000, 16'd1200, 32'd2000, 10'd10));
    send_tick(mk_tick(1'b1, 32'd2010, 16'd700, 32'd2010, 10'd10));
    send_tick(mk_tick(1'b1, 32'd2020, 16'd701, 32'd2020, 10'd10));
    send_tick(mk_tick(1'b1, 32'd2030, 16'd699, 32'd2030, 10'd10));
    c = '{desired: 16'd1000, min_safe: 16'd200, deadband: 12'd10, gain: 12'd2000,
          fwd_max: 12'd50, rev_max: 13'sd300, accel: 16'd1000, hold_time: 16'd100};
    apply_settings(c);
    send_tick(mk_tick(1'b1, 32'd2040, 16'd3000, 32'd2040, 10'd1023));
    send_tick(mk_tick(1'b1, 32'd2050, 16'd400, 32'd2050, 10'd1023));
    send_tick(mk_tick(1'b1, 32'd2060, 16'd100, 32'd2060, 10'd1023));
    send_tick(mk_tick(1'b1, 32'd2070, 16'd1005, 32'd2070, 10'd1023));
  endtask

  // The block fills up behind a stalled receiver, then the sender waits for it to empty.
  task automatic test_full_pressure();
    apply_settings(DEFAULT_CFG);
    tx_gap_max = 0;
    rx_hold_cycles = 250;
    repeat (30) send_tick(next_random_tick());
    tx_gap_max = 10;
    repeat (20) send_tick(next_random_tick());
    drain_plans();
    repeat (20) send_tick(next_random_tick());
  endtask

  task automatic test_random_settings();
    cfg_t c;
    int   rv;
    for (int s = 0; s < 8; s++) begin
      case (s)
        0: c = DEFAULT_CFG;
        1: c = '{desired: 16'd3000, min_safe: 16'd500, deadband: 12'd4095, gain: 12'd4095,
                 fwd_max: 12'd4000, rev_max: -13'sd4000, accel: 16'hFFFF,
                 hold_time: 16'hFFFF};
        2: c = '{desired: 16'd0, min_safe: 16'd0, deadband: 12'd1, gain: 12'd0,
                 fwd_max: 12'd0, rev_max: 13'sd0, accel: 16'd0, hold_time: 16'd0};
        3: c = '{desired: 16'hFFFF, min_safe: 16'hFFFF, deadband: 12'd1, gain: 12'd1,
                 fwd_max: 12'd1, rev_max: -13'sd1, accel: 16'd1, hold_time: 16'd1};
        default: begin
          c.desired = 16'($urandom_range(0, 65535));
          c.min_safe = 16'($urandom_range(0, 65535));
          c.deadband = 12'($urandom_range(1, 4095));
          c.gain = 12'($urandom_range(0, 4095));
          c.fwd_max = 12'($urandom_range(0, 4000));
          rv = -int'($urandom_range(0, 4000));
          c.rev_max = 13'(rv);
          c.accel = 16'($urandom_range(0, 65535));
          c.hold_time = 16'($urandom_range(0, 1000));
        end
      endcase
      apply_settings(c);
      for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
        // Idling comes and goes in blocks, so some stretches run back to back.
        if (i % 50 == 0) begin
          tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
          rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
        end
        send_tick(next_random_tick());
      end
    end
    tx_gap_max = 10;
    rx_gap_max = 10;
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    target_present = 1'b0;
    sample_time_ms = '0;
    front_distance_mm = '0;
    now_time_ms = '0;
    tick_ms = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_ticks();
    test_special_limits();
    test_full_pressure();
    test_random_settings();
    drain_plans();

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/tfsp_pkg.sv
design/tfsp_regs.sv
design/tfsp_alu.sv
design/target_follow_speed_planner.sv
bench/target_follow_speed_planner_test.sv
